// ===== hw/rtl/vbba_pkg.sv =====
`timescale 1ns / 1ps

package vbba_pkg;

    // Width of the reported area; wider results saturate to all ones.
    localparam int unsigned BOX_AREA_W = 32;

    typedef logic [BOX_AREA_W-1:0] box_area_t;

    localparam box_area_t BOX_AREA_MAX = '1;

endpackage

// ===== hw/rtl/vbba_tracker.sv =====
`timescale 1ns / 1ps

module vbba_tracker import vbba_pkg::*; #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         take,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS:0]   in_sum,
    input  logic signed [COORD_BITS:0]   in_diff,
    input  logic                         in_last,
    output logic                         ready,
    output logic                         span_valid,
    input  logic                         span_ready,
    output logic        [COORD_BITS-1:0] span_x,
    output logic        [COORD_BITS-1:0] span_y,
    output logic        [COORD_BITS:0]   span_sum,
    output logic        [COORD_BITS:0]   span_diff
);

    localparam int unsigned CW = COORD_BITS;

    logic                 set_empty_reg, set_empty_next;
    logic                 span_valid_reg, span_valid_next;
    logic signed [CW-1:0] low_x_reg, high_x_reg, low_y_reg, high_y_reg;
    logic signed [CW-1:0] low_x_next, high_x_next, low_y_next, high_y_next;
    logic signed [CW:0]   low_sum_reg, high_sum_reg, low_diff_reg, high_diff_reg;
    logic signed [CW:0]   low_sum_next, high_sum_next, low_diff_next, high_diff_next;
    logic        [CW-1:0] span_x_reg, span_y_reg;
    logic        [CW:0]   span_sum_reg, span_diff_reg;
    logic signed [CW:0]   dx_w, dy_w;
    logic signed [CW+1:0] ds_w, dd_w;

    // The first vertex of a set loads every extreme, later ones widen them.
    always_comb begin
        low_x_next     = (set_empty_reg || in_x < low_x_reg)     ? in_x    : low_x_reg;
        high_x_next    = (set_empty_reg || in_x > high_x_reg)    ? in_x    : high_x_reg;
        low_y_next     = (set_empty_reg || in_y < low_y_reg)     ? in_y    : low_y_reg;
        high_y_next    = (set_empty_reg || in_y > high_y_reg)    ? in_y    : high_y_reg;
        low_sum_next   = (set_empty_reg || in_sum < low_sum_reg)   ? in_sum  : low_sum_reg;
        high_sum_next  = (set_empty_reg || in_sum > high_sum_reg)  ? in_sum  : high_sum_reg;
        low_diff_next  = (set_empty_reg || in_diff < low_diff_reg) ? in_diff : low_diff_reg;
        high_diff_next = (set_empty_reg || in_diff > high_diff_reg)? in_diff : high_diff_reg;
    end

    assign dx_w = {high_x_next[CW-1], high_x_next} - {low_x_next[CW-1], low_x_next};
    assign dy_w = {high_y_next[CW-1], high_y_next} - {low_y_next[CW-1], low_y_next};
    assign ds_w = {high_sum_next[CW], high_sum_next} - {low_sum_next[CW], low_sum_next};
    assign dd_w = {high_diff_next[CW], high_diff_next} - {low_diff_next[CW], low_diff_next};

    assign ready           = !span_valid_reg || span_ready;
    assign set_empty_next  = take ? in_last : set_empty_reg;
    assign span_valid_next = (take && in_last) ? 1'b1 :
                             (span_ready ? 1'b0 : span_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_empty_reg  <= 1'b1;
            span_valid_reg <= 1'b0;
        end else begin
            set_empty_reg  <= set_empty_next;
            span_valid_reg <= span_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            low_x_reg     <= low_x_next;
            high_x_reg    <= high_x_next;
            low_y_reg     <= low_y_next;
            high_y_reg    <= high_y_next;
            low_sum_reg   <= low_sum_next;
            high_sum_reg  <= high_sum_next;
            low_diff_reg  <= low_diff_next;
            high_diff_reg <= high_diff_next;
        end
        if (take && in_last) begin
            span_x_reg    <= dx_w[CW-1:0];
            span_y_reg    <= dy_w[CW-1:0];
            span_sum_reg  <= ds_w[CW:0];
            span_diff_reg <= dd_w[CW:0];
        end
    end

    assign span_valid = span_valid_reg;
    assign span_x     = span_x_reg;
    assign span_y     = span_y_reg;
    assign span_sum   = span_sum_reg;
    assign span_diff  = span_diff_reg;

endmodule

// ===== hw/rtl/vbba_area.sv =====
`timescale 1ns / 1ps

module vbba_area import vbba_pkg::*; #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  span_valid,
    output logic                  span_ready,
    input  logic [COORD_BITS-1:0] span_x,
    input  logic [COORD_BITS-1:0] span_y,
    input  logic [COORD_BITS:0]   span_sum,
    input  logic [COORD_BITS:0]   span_diff,
    output logic                  m_valid,
    input  logic                  m_ready,
    output box_area_t             m_box_area,
    output logic                  m_diagonal_chosen
);

    localparam int unsigned CW     = COORD_BITS;
    localparam int unsigned AXIS_W = 2 * CW;
    localparam int unsigned DIAG_W = 2 * CW + 1;
    // At least one bit above the output width so the overflow test is always legal.
    localparam int unsigned WIDE_W = ((DIAG_W > BOX_AREA_W) ? DIAG_W : BOX_AREA_W) + 1;

    logic                prod_valid_reg, prod_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                prod_ready, out_ready;
    logic [AXIS_W-1:0]   axis_full, axis_reg;
    logic [DIAG_W:0]     diag_full;
    logic [DIAG_W-1:0]   diag_reg;
    logic                pick_diag;
    logic [DIAG_W-1:0]   pick_area;
    logic [WIDE_W-1:0]   wide_area;
    box_area_t           area_sat;
    box_area_t           area_reg;
    logic                diag_chosen_reg;

    assign axis_full = {{CW{1'b0}}, span_x} * {{CW{1'b0}}, span_y};
    assign diag_full = {{(CW + 1){1'b0}}, span_sum} * {{(CW + 1){1'b0}}, span_diff};

    // A tie keeps the axis-aligned area.
    assign pick_diag = diag_reg < {1'b0, axis_reg};
    assign pick_area = pick_diag ? diag_reg : {1'b0, axis_reg};
    assign wide_area = WIDE_W'(pick_area);
    assign area_sat  = (|wide_area[WIDE_W-1:BOX_AREA_W]) ? BOX_AREA_MAX
                                                        : wide_area[BOX_AREA_W-1:0];

    assign out_ready  = !out_valid_reg || m_ready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign span_ready = prod_ready;

    assign prod_valid_next = span_valid ? 1'b1 : (out_ready ? 1'b0 : prod_valid_reg);
    assign out_valid_next  = prod_valid_reg ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= prod_valid_next;
            end
            if (out_ready) begin
                out_valid_reg <= out_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (span_valid && prod_ready) begin
            axis_reg <= axis_full;
            diag_reg <= diag_full[DIAG_W:1];
        end
        if (prod_valid_reg && out_ready) begin
            area_reg        <= area_sat;
            diag_chosen_reg <= pick_diag;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_box_area        = area_reg;
    assign m_diagonal_chosen = diag_chosen_reg;

endmodule

// ===== hw/rtl/vertex_bounding_box_area.sv =====
`timescale 1ns / 1ps
// The result of a set passes the input register, extreme tracker, multiplier stage and
// output register before m_valid. Throughput: one vertex per cycle while nothing stalls;
// each of these stages holds one request and stalls only when the one below is full.
// Reset: aresetn is synchronous and active low; it empties every stage and marks the
// next vertex as the first of a new set.

module vertex_bounding_box_area import vbba_pkg::*; #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_vertex_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_y,
    input  logic                         s_last_vertex,
    output logic                         m_valid,
    input  logic                         m_ready,
    output box_area_t                    m_box_area,
    output logic                         m_diagonal_chosen
);

    localparam int unsigned CW = COORD_BITS;

    logic                 in_valid_reg, in_valid_next;
    logic signed [CW-1:0] in_x_reg, in_y_reg;
    logic signed [CW:0]   in_sum_reg, in_diff_reg;
    logic                 in_last_reg;
    logic                 in_move;
    logic                 trk_ready;
    logic                 span_valid, span_ready;
    logic        [CW-1:0] span_x, span_y;
    logic        [CW:0]   span_sum, span_diff;

    // A vertex without the last mark never waits: it only updates the extremes.
    assign in_move       = in_valid_reg && (!in_last_reg || trk_ready);
    assign s_ready       = !in_valid_reg || in_move;
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (in_move ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_x_reg    <= s_vertex_x;
            in_y_reg    <= s_vertex_y;
            in_sum_reg  <= {s_vertex_x[CW-1], s_vertex_x} + {s_vertex_y[CW-1], s_vertex_y};
            in_diff_reg <= {s_vertex_x[CW-1], s_vertex_x} - {s_vertex_y[CW-1], s_vertex_y};
            in_last_reg <= s_last_vertex;
        end
    end

    vbba_tracker #(
        .COORD_BITS (COORD_BITS)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (in_move),
        .in_x       (in_x_reg),
        .in_y       (in_y_reg),
        .in_sum     (in_sum_reg),
        .in_diff    (in_diff_reg),
        .in_last    (in_last_reg),
        .ready      (trk_ready),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span_x     (span_x),
        .span_y     (span_y),
        .span_sum   (span_sum),
        .span_diff  (span_diff)
    );

    vbba_area #(
        .COORD_BITS (COORD_BITS)
    ) u_area (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .span_valid        (span_valid),
        .span_ready        (span_ready),
        .span_x            (span_x),
        .span_y            (span_y),
        .span_sum          (span_sum),
        .span_diff         (span_diff),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_box_area        (m_box_area),
        .m_diagonal_chosen (m_diagonal_chosen)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import vbba_pkg::*;

    localparam int COORD_BITS     = 16;
    localparam int LATENCY        = 3;
    localparam int LONG_HOLD      = 200;
    localparam int IDLE_LIMIT     = 2000;
    localparam int TOTAL_VERTICES = 950;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   wide_coord_t;

    typedef struct packed {
        box_area_t area;
        logic      diagonal;
    } box_result_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    coord_t    s_vertex_x = '0;
    coord_t    s_vertex_y = '0;
    logic      s_last_vertex = 1'b0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    box_area_t m_box_area;
    logic      m_diagonal_chosen;

    // Running extremes of the open polygon set, mirrored from the block.
    bit          set_fresh = 1'b1;
    coord_t      min_x = '0, max_x = '0, min_y = '0, max_y = '0;
    wide_coord_t min_sum = '0, max_sum = '0, min_diff = '0, max_diff = '0;

    box_result_t pending_areas[$];

    int  error_count = 0;
    int  vertices_sent = 0;
    int  sets_closed = 0;
    int  diagonal_picks = 0;
    int  areas_checked = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  rx_gap_left = 0;

    vertex_bounding_box_area #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_vertex_x        (s_vertex_x),
        .s_vertex_y        (s_vertex_y),
        .s_last_vertex     (s_last_vertex),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_box_area        (m_box_area),
        .m_diagonal_chosen (m_diagonal_chosen)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Folds one accepted vertex into the extremes and, on the last vertex of a set,
    // queues the area that the block should report.
    function automatic void fold_vertex(input coord_t x, input coord_t y, input logic last);
        wide_coord_t sum_v;
        wide_coord_t diff_v;
        longint      axis;
        longint      diag;
        longint      area;
        box_result_t res;
        sum_v  = x + y;
        diff_v = x - y;
        if (set_fresh) begin
            set_fresh = 1'b0;
            min_x = x;          max_x = x;
            min_y = y;          max_y = y;
            min_sum = sum_v;    max_sum = sum_v;
            min_diff = diff_v;  max_diff = diff_v;
        end else begin
            if (x < min_x) min_x = x;
            if (x > max_x) max_x = x;
            if (y < min_y) min_y = y;
            if (y > max_y) max_y = y;
            if (sum_v < min_sum) min_sum = sum_v;
            if (sum_v > max_sum) max_sum = sum_v;
            if (diff_v < min_diff) min_diff = diff_v;
            if (diff_v > max_diff) max_diff = diff_v;
        end
        if (!last) return;
        axis = (longint'(max_x) - longint'(min_x)) * (longint'(max_y) - longint'(min_y));
        diag = ((longint'(max_sum) - longint'(min_sum))
               * (longint'(max_diff) - longint'(min_diff))) >>> 1;
        // A tie keeps the axis-aligned area.
        res.diagonal = (diag < axis);
        area = res.diagonal ? diag : axis;
        res.area = (area > 64'hFFFF_FFFF) ? BOX_AREA_MAX : box_area_t'(area);
        pending_areas.push_back(res);
        sets_closed++;
        if (res.diagonal) diagonal_picks++;
        set_fresh = 1'b1;
        min_x = '0;    max_x = '0;    min_y = '0;    max_y = '0;
        min_sum = '0;  max_sum = '0;  min_diff = '0; max_diff = '0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Leaves valid high after the handshake when no gap follows, so the next
    // request goes out back to back.
    task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
        int gap;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_vertex_x    <= x;
        s_vertex_y    <= y;
        s_last_vertex <= last;
        do @(posedge aclk); while (!s_ready);
        fold_vertex(x, y, last);
        vertices_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_areas.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    function automatic coord_t pick_coord(input int style, input int centre);
        case (style)
            0: return coord_t'($urandom);
            1: return coord_t'(centre + int'($urandom_range(0, 512)) - 256);
            default: begin
                case ($urandom_range(0, 6))
                    0: return coord_t'(-32768);
                    1: return coord_t'(-32767);
                    2: return coord_t'(-1);
                    3: return coord_t'(0);
                    4: return coord_t'(1);
                    5: return coord_t'(32766);
                    default: return coord_t'(32767);
                endcase
            end
        endcase
    endfunction

    task automatic test_directed_shapes();
        // Single-vertex sets give a zero area.
        send_vertex(0, 0, 1'b1);
        send_vertex(-32768, 32767, 1'b1);
        // Equal areas: the axis box wins the tie.
        send_vertex(0, 0, 1'b0);
        send_vertex(2, 0, 1'b0);
        send_vertex(0, 2, 1'b1);
        // Diamond, where the rotated box is smaller.
        send_vertex(0, 1, 1'b0);
        send_vertex(1, 0, 1'b0);
        send_vertex(0, -1, 1'b0);
        send_vertex(-1, 0, 1'b1);
        // Odd diagonal product, so the half is rounded down.
        send_vertex(0, 0, 1'b0);
        send_vertex(2, 1, 1'b1);
        // Full coordinate range: largest axis area, diagonal product over 32 bits.
        send_vertex(-32768, -32768, 1'b0);
        send_vertex(32767, -32768, 1'b0);
        send_vertex(32767, 32767, 1'b0);
        send_vertex(-32768, 32767, 1'b1);
        send_vertex(-32768, -32768, 1'b0);
        send_vertex(32767, 32767, 1'b1);
        send_vertex(-32768, 32767, 1'b0);
        send_vertex(32767, -32768, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_sets(input int upto);
        int len;
        int style;
        int centre;
        int r;
        while (vertices_sent < upto) begin
            r = $urandom_range(0, 99);
            if (r < 15) len = 1;
            else if (r < 85) len = $urandom_range(2, 8);
            else len = $urandom_range(9, 30);
            style  = $urandom_range(0, 2);
            centre = int'($urandom_range(0, 64000)) - 32000;
            for (int i = 0; i < len; i++) begin
                send_vertex(pick_coord(style, centre), pick_coord(style, centre), i == len - 1);
            end
        end
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        int target;
        int len;
        target = vertices_sent + 60;
        @(posedge aclk);
        no_gaps = 1'b1;
        while (vertices_sent < target) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                send_vertex(pick_coord(1, 100), pick_coord(0, 0), i == len - 1);
            end
        end
        wait_for_results();
        no_gaps = 1'b0;
    endtask

    // The result side stops for a long stretch while single-vertex sets keep
    // coming, so every stage fills and the input stalls.
    task automatic test_output_backpressure();
        @(posedge aclk);
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (24) send_vertex(pick_coord(0, 0), pick_coord(0, 0), 1'b1);
        wait_for_results();
        no_gaps = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_ready <= 1'b0;
        end else if (no_gaps || $urandom_range(0, 99) < 60) begin
            m_ready <= 1'b1;
        end else begin
            rx_gap_left = pick_gap();
            if (rx_gap_left > 0) rx_gap_left--;
            m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        box_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_areas.size() == 0) begin
                report_mismatch($sformatf("area %0d arrived with none expected", m_box_area));
            end else begin
                want = pending_areas.pop_front();
                areas_checked++;
                if (m_box_area !== want.area)
                    report_mismatch($sformatf("box_area %0d, expected %0d",
                                              m_box_area, want.area));
                if (m_diagonal_chosen !== want.diagonal)
                    report_mismatch($sformatf("diagonal_chosen %0b, expected %0b",
                                              m_diagonal_chosen, want.diagonal));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TIMEOUT: no request accepted in %0d cycles", IDLE_LIMIT);
                $display("vertex_bounding_box_area verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_shapes();
        test_random_sets(450);
        test_back_to_back();
        test_output_backpressure();
        test_random_sets(TOTAL_VERTICES);
        $display("Sent %0d vertices in %0d polygon sets; %0d areas checked, %0d of them",
                 vertices_sent, sets_closed, areas_checked, diagonal_picks);
        $display("from the 45-degree box, with random stalls on both sides.");
        if (error_count == 0) begin
            $display("vertex_bounding_box_area verification clean");
        end else begin
            $display("vertex_bounding_box_area verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vbba_pkg.sv
hw/rtl/vbba_tracker.sv
hw/rtl/vbba_area.sv
hw/rtl/vertex_bounding_box_area.sv
tb/sv/testbench.sv
